>>> sv/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants and elaboration-time helpers for the great circle distance
// pipeline: fixed-point formats, degree to radian scaling, cordic angle table.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int CORDIC_STAGES_DEF = 32;

    // Q61 fixed point
    localparam logic [63:0] PI_Q61 = 64'h6487_ED51_10B4_611A;
    localparam logic signed [63:0] HALF_PI_Q61 = $signed(PI_Q61 >> 1);
    localparam logic signed [63:0] K_Q61 = 64'sd1400229935014726477;
    localparam logic signed [63:0] EPS_Q61 = 64'sd2305843009214;

    // degree count (1e-7 deg) to Q61 radians: round(u * PI_Q61 / TORAD_DIV)
    localparam logic [63:0] TORAD_DIV = 64'd1800000000;
    localparam logic [63:0] TORAD_HALF = 64'd900000000;
    localparam logic [63:0] PI_DIV = PI_Q61 / TORAD_DIV;
    localparam logic [63:0] PI_MOD = PI_Q61 % TORAD_DIV;
    // reciprocal estimate of PI_MOD / TORAD_DIV in Q32
    localparam logic [63:0] TORAD_RECIP = (PI_MOD << 32) / TORAD_DIV;

    localparam logic [32:0] RADIUS_RESET = 33'd6371000000;
    localparam logic [34:0] DIST_MAX = 35'h7_FFFF_FFFF;

    // floor(2^e / d) by shift and subtract, elaboration only
    function automatic logic [63:0] pow2_div(input int e, input logic [63:0] d);
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        num = 64'd1 << e;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= d) begin
                rem = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q61 from the alternating series
    function automatic logic signed [63:0] atan_entry(input int i);
        logic signed [63:0] acc;
        int e;
        acc = '0;
        if (i == 0) begin
            acc = $signed(PI_Q61 >> 2);
        end else begin
            for (int k = 0; k < 64; k++) begin
                e = 61 - i * (2 * k + 1);
                if (e >= 0) begin
                    if (k % 2 == 1) begin
                        acc = acc - $signed(pow2_div(e, 64'(2 * k + 1)));
                    end else begin
                        acc = acc + $signed(pow2_div(e, 64'(2 * k + 1)));
                    end
                end
            end
        end
        return acc;
    endfunction

endpackage

>>> sv/gcd_delay.sv
// ----------------------------------------------------------------------------
// gcd_delay
// Fixed-depth register line that carries side data alongside the datapath.
// ----------------------------------------------------------------------------
module gcd_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        r_q[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_q[k] <= r_q[k-1];
        end
    end

    assign o_q = r_q[DEPTH-1];

endmodule

>>> sv/gcd_torad.sv
// ----------------------------------------------------------------------------
// gcd_torad
// Three-stage conversion of a degree count to Q61 radians with rounding,
// using a reciprocal estimate and a remainder correction.
// ----------------------------------------------------------------------------
module gcd_torad
    import gcd_pkg::*;
(
    input  logic               i_clk,
    input  logic [29:0]        i_u,
    output logic signed [63:0] o_z
);

    logic [61:0] r_a;
    logic [60:0] r_b;
    logic [61:0] r_e;
    logic [61:0] r2_a;
    logic [61:0] r2_b;
    logic [29:0] r2_q;
    logic [60:0] r2_m;
    logic [63:0] r_z;
    logic [61:0] n_rem;
    logic [29:0] n_q;

    always_ff @(posedge i_clk) begin
        r_a <= {32'd0, i_u} * {30'd0, PI_DIV[31:0]};
        r_b <= {31'd0, i_u} * {30'd0, PI_MOD[30:0]};
        r_e <= {32'd0, i_u} * {30'd0, TORAD_RECIP[31:0]};
    end

    always_ff @(posedge i_clk) begin
        r2_a <= r_a;
        r2_b <= 62'(r_b) + 62'(TORAD_HALF);
        r2_q <= r_e[61:32];
        r2_m <= {31'd0, r_e[61:32]} * {30'd0, TORAD_DIV[30:0]};
    end

    // estimate is low by at most two
    always_comb begin
        n_rem = r2_b - 62'(r2_m);
        if (n_rem >= 62'(TORAD_DIV << 1)) begin
            n_q = r2_q + 30'd2;
        end else if (n_rem >= 62'(TORAD_DIV)) begin
            n_q = r2_q + 30'd1;
        end else begin
            n_q = r2_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z <= 64'(r2_a) + 64'(n_q);
    end

    assign o_z = $signed(r_z);

endmodule

>>> sv/gcd_cordic.sv
// ----------------------------------------------------------------------------
// gcd_cordic
// Fully unrolled cordic, one register stage per iteration, rotation or
// vectoring mode.
// ----------------------------------------------------------------------------
module gcd_cordic
    import gcd_pkg::*;
#(
    parameter int STAGES    = CORDIC_STAGES_DEF,
    parameter bit VECTORING = 1'b0
) (
    input  logic               i_clk,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_z,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic signed [63:0] o_z
);

    logic signed [63:0] r_x [STAGES];
    logic signed [63:0] r_y [STAGES];
    logic signed [63:0] r_z [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [63:0] ATAN = atan_entry(i);
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] pz;
        logic               sub;

        if (i == 0) begin : g_first
            assign px = i_x;
            assign py = i_y;
            assign pz = i_z;
        end else begin : g_next
            assign px = r_x[i-1];
            assign py = r_y[i-1];
            assign pz = r_z[i-1];
        end

        assign sub = VECTORING ? (py > 64'sd0) : (pz < 64'sd0);

        always_ff @(posedge i_clk) begin
            if (sub) begin
                r_x[i] <= px + (py >>> i);
                r_y[i] <= py - (px >>> i);
                r_z[i] <= pz + ATAN;
            end else begin
                r_x[i] <= px - (py >>> i);
                r_y[i] <= py + (px >>> i);
                r_z[i] <= pz - ATAN;
            end
        end
    end

    assign o_x = r_x[STAGES-1];
    assign o_y = r_y[STAGES-1];
    assign o_z = r_z[STAGES-1];

endmodule

>>> sv/gcd_mul.sv
// ----------------------------------------------------------------------------
// gcd_mul
// Signed fixed-point multiply in three stages: magnitudes, four 32x32
// partial products, then sum, truncating shift and sign.
// ----------------------------------------------------------------------------
module gcd_mul #(
    parameter int SHIFT = 61
) (
    input  logic               i_clk,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg;
    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic         r2_neg;
    logic [63:0]  r_p;
    logic [127:0] n_sum;
    logic [63:0]  n_mag;

    always_ff @(posedge i_clk) begin
        r_ua  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
        r_ub  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
        r_neg <= i_a[63] ^ i_b[63];
    end

    always_ff @(posedge i_clk) begin
        r_ll   <= {32'd0, r_ua[31:0]}  * {32'd0, r_ub[31:0]};
        r_lh   <= {32'd0, r_ua[31:0]}  * {32'd0, r_ub[63:32]};
        r_hl   <= {32'd0, r_ua[63:32]} * {32'd0, r_ub[31:0]};
        r_hh   <= {32'd0, r_ua[63:32]} * {32'd0, r_ub[63:32]};
        r2_neg <= r_neg;
    end

    always_comb begin
        n_sum = {r_hh, 64'd0} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0}
              + {64'd0, r_ll};
        n_mag = n_sum[SHIFT+63:SHIFT];
    end

    always_ff @(posedge i_clk) begin
        r_p <= r2_neg ? -n_mag : n_mag;
    end

    assign o_p = $signed(r_p);

endmodule

>>> sv/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Distance between two GPS points: cordic sines and cosines, atan2 central
// angle, radius scaling and altitude hypotenuse, fully pipelined.
// ----------------------------------------------------------------------------
// throughput: one word per cycle; busy never rises, four cordic chains set the depth
// results cannot be stalled: each shows for one cycle with o_valid
// reset (i_rst_n low, synchronous) empties the pipeline and loads the
// default radius; cfg writes are taken at once
module great_circle_distance
    import gcd_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [27:0] i_alt_a,
    input  logic signed [31:0] i_lon_b,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [27:0] i_alt_b,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [32:0]        i_cfg_data,
    output logic               o_valid,
    output logic [34:0]        o_distance_mm,
    output logic               o_saturated
);

    localparam int N   = CORDIC_STAGES;
    localparam int LAT = 25 + 4 * N;
    localparam logic [30:0] LAT_MAX = 31'd900000000;
    localparam logic signed [33:0] LON_FULL = 34'sd3600000000;
    localparam logic signed [33:0] LON_HALF = 34'sd1800000000;
    localparam logic signed [33:0] LON_QTR  = 34'sd900000000;

    logic [32:0]  r_radius;
    logic [LAT-1:0] r_vld;

    // ---- input stage
    logic [30:0] n_mag_a;
    logic [30:0] n_mag_b;
    logic [29:0] r_p1_ua;
    logic [29:0] r_p1_ub;
    logic        r_p1_nega;
    logic        r_p1_negb;
    logic signed [32:0] r_p1_dlon;
    logic signed [27:0] r_p1_alta;
    logic signed [27:0] r_p1_altb;

    always_comb begin
        n_mag_a = i_lat_a[30] ? 31'(-i_lat_a) : 31'(i_lat_a);
        n_mag_b = i_lat_b[30] ? 31'(-i_lat_b) : 31'(i_lat_b);
    end

    always_ff @(posedge i_clk) begin
        r_p1_ua   <= (n_mag_a > LAT_MAX) ? LAT_MAX[29:0] : n_mag_a[29:0];
        r_p1_ub   <= (n_mag_b > LAT_MAX) ? LAT_MAX[29:0] : n_mag_b[29:0];
        r_p1_nega <= i_lat_a[30];
        r_p1_negb <= i_lat_b[30];
        r_p1_dlon <= 33'(i_lon_b) - 33'(i_lon_a);
        r_p1_alta <= i_alt_a;
        r_p1_altb <= i_alt_b;
    end

    // ---- longitude fold into [0, 90] degrees
    logic signed [33:0] n_d;
    logic signed [33:0] n_m0;
    logic signed [33:0] n_m1;
    logic signed [33:0] n_m2;
    logic               n_cneg;
    logic [29:0] r_p2_ua;
    logic [29:0] r_p2_ub;
    logic [29:0] r_p2_ud;
    logic [2:0]  r_p2_sgn;
    logic signed [27:0] r_p2_alta;
    logic signed [27:0] r_p2_altb;

    always_comb begin
        n_d = 34'(r_p1_dlon);
        if (n_d >= LON_FULL) begin
            n_m0 = n_d - LON_FULL;
        end else if (n_d < -LON_FULL) begin
            n_m0 = n_d + LON_FULL + LON_FULL;
        end else if (n_d < 34'sd0) begin
            n_m0 = n_d + LON_FULL;
        end else begin
            n_m0 = n_d;
        end
        n_m1 = (n_m0 > LON_HALF) ? LON_FULL - n_m0 : n_m0;
        n_cneg = n_m1 > LON_QTR;
        n_m2 = n_cneg ? LON_HALF - n_m1 : n_m1;
    end

    always_ff @(posedge i_clk) begin
        r_p2_ua   <= r_p1_ua;
        r_p2_ub   <= r_p1_ub;
        r_p2_ud   <= n_m2[29:0];
        r_p2_sgn  <= {n_cneg, r_p1_negb, r_p1_nega};
        r_p2_alta <= r_p1_alta;
        r_p2_altb <= r_p1_altb;
    end

    // ---- radians and sines / cosines
    logic signed [63:0] w_za, w_zb, w_zd;
    logic signed [63:0] w_c1, w_s1, w_c2, w_s2, w_cd, w_sd;
    logic [2:0]         w_sgn;
    logic [55:0]        w_alts;

    gcd_torad u_rad_a (.i_clk(i_clk), .i_u(r_p2_ua), .o_z(w_za));
    gcd_torad u_rad_b (.i_clk(i_clk), .i_u(r_p2_ub), .o_z(w_zb));
    gcd_torad u_rad_d (.i_clk(i_clk), .i_u(r_p2_ud), .o_z(w_zd));

    gcd_cordic #(.STAGES(N), .VECTORING(1'b0)) u_rot_a (
        .i_clk(i_clk), .i_x(K_Q61), .i_y(64'sd0), .i_z(w_za),
        .o_x(w_c1), .o_y(w_s1), .o_z()
    );
    gcd_cordic #(.STAGES(N), .VECTORING(1'b0)) u_rot_b (
        .i_clk(i_clk), .i_x(K_Q61), .i_y(64'sd0), .i_z(w_zb),
        .o_x(w_c2), .o_y(w_s2), .o_z()
    );
    gcd_cordic #(.STAGES(N), .VECTORING(1'b0)) u_rot_d (
        .i_clk(i_clk), .i_x(K_Q61), .i_y(64'sd0), .i_z(w_zd),
        .o_x(w_cd), .o_y(w_sd), .o_z()
    );

    gcd_delay #(.W(3), .DEPTH(3 + N)) u_dly_sgn (
        .i_clk(i_clk), .i_d(r_p2_sgn), .o_q(w_sgn)
    );
    gcd_delay #(.W(56), .DEPTH(15 + 3 * N)) u_dly_alt (
        .i_clk(i_clk), .i_d({r_p2_altb, r_p2_alta}), .o_q(w_alts)
    );

    // ---- sign fix for negative latitudes and obtuse longitude difference
    logic signed [63:0] r_c1, r_s1, r_c2, r_s2, r_cd, r_sd;

    always_ff @(posedge i_clk) begin
        r_c1 <= w_c1;
        r_c2 <= w_c2;
        r_sd <= w_sd;
        r_s1 <= w_sgn[0] ? -w_s1 : w_s1;
        r_s2 <= w_sgn[1] ? -w_s2 : w_s2;
        r_cd <= w_sgn[2] ? -w_cd : w_cd;
    end

    // ---- products
    logic signed [63:0] w_tf, w_p1, w_p2, w_p3, w_p4, w_cd3;
    logic signed [63:0] w_q2, w_q4, w_tf3, w_p13, w_p33;

    gcd_mul u_mul_tf (.i_clk(i_clk), .i_a(r_c2), .i_b(r_sd), .o_p(w_tf));
    gcd_mul u_mul_p1 (.i_clk(i_clk), .i_a(r_c1), .i_b(r_s2), .o_p(w_p1));
    gcd_mul u_mul_p2 (.i_clk(i_clk), .i_a(r_s1), .i_b(r_c2), .o_p(w_p2));
    gcd_mul u_mul_p3 (.i_clk(i_clk), .i_a(r_s1), .i_b(r_s2), .o_p(w_p3));
    gcd_mul u_mul_p4 (.i_clk(i_clk), .i_a(r_c1), .i_b(r_c2), .o_p(w_p4));
    gcd_delay #(.W(64), .DEPTH(3)) u_dly_cd (.i_clk(i_clk), .i_d(r_cd), .o_q(w_cd3));

    gcd_mul u_mul_q2 (.i_clk(i_clk), .i_a(w_p2), .i_b($signed(w_cd3)), .o_p(w_q2));
    gcd_mul u_mul_q4 (.i_clk(i_clk), .i_a(w_p4), .i_b($signed(w_cd3)), .o_p(w_q4));
    gcd_delay #(.W(192), .DEPTH(3)) u_dly_pr (
        .i_clk(i_clk), .i_d({w_tf, w_p1, w_p3}), .o_q({w_tf3, w_p13, w_p33})
    );

    // ---- atan2 operands
    logic signed [63:0] n_ts;
    logic signed [63:0] r_x0, r_y0, r_bot;

    assign n_ts = w_p13 - w_q2;

    always_ff @(posedge i_clk) begin
        r_x0  <= w_tf3[63] ? -w_tf3 : w_tf3;
        r_y0  <= n_ts[63] ? -n_ts : n_ts;
        r_bot <= w_p33 + w_q4;
    end

    logic signed [63:0] w_mx, w_top, w_bot;

    gcd_cordic #(.STAGES(N), .VECTORING(1'b1)) u_vec_top (
        .i_clk(i_clk), .i_x(r_x0), .i_y(r_y0), .i_z(64'sd0),
        .o_x(w_mx), .o_y(), .o_z()
    );
    gcd_mul u_mul_top (.i_clk(i_clk), .i_a(w_mx), .i_b(K_Q61), .o_p(w_top));
    gcd_delay #(.W(64), .DEPTH(N + 3)) u_dly_bot (
        .i_clk(i_clk), .i_d(r_bot), .o_q(w_bot)
    );

    // ---- central angle, left half plane starts a quarter turn on
    logic signed [63:0] n_babs;
    logic               r_zero;
    logic signed [63:0] r_vx, r_vy, r_vz;

    assign n_babs = w_bot[63] ? -$signed(w_bot) : $signed(w_bot);

    always_ff @(posedge i_clk) begin
        r_zero <= (w_top < EPS_Q61) && (n_babs < EPS_Q61);
        if (w_bot[63]) begin
            r_vx <= w_top;
            r_vy <= -$signed(w_bot);
            r_vz <= HALF_PI_Q61;
        end else begin
            r_vx <= $signed(w_bot);
            r_vy <= w_top;
            r_vz <= 64'sd0;
        end
    end

    logic signed [63:0] w_ang;
    logic               w_zero;

    gcd_cordic #(.STAGES(N), .VECTORING(1'b1)) u_vec_ang (
        .i_clk(i_clk), .i_x(r_vx), .i_y(r_vy), .i_z(r_vz),
        .o_x(), .o_y(), .o_z(w_ang)
    );
    gcd_delay #(.W(1), .DEPTH(N)) u_dly_zero (
        .i_clk(i_clk), .i_d(r_zero), .o_q(w_zero)
    );

    // ---- scale and altitude leg
    logic signed [27:0] w_alta, w_altb;
    logic signed [27:0] n_amin;
    logic signed [34:0] n_scale;
    logic signed [28:0] n_diff;
    logic [28:0]        n_dabs;
    logic signed [63:0] r_ang, r_scale, r_dy;
    logic               r_dz;

    always_comb begin
        w_alta  = w_alts[27:0];
        w_altb  = w_alts[55:28];
        n_amin  = (w_altb < w_alta) ? w_altb : w_alta;
        n_scale = $signed({2'b00, r_radius}) + 35'(n_amin);
        n_diff  = 29'(w_altb) - 29'(w_alta);
        n_dabs  = n_diff[28] ? 29'(-n_diff) : 29'(n_diff);
    end

    always_ff @(posedge i_clk) begin
        r_ang   <= (w_zero || w_ang[63]) ? 64'sd0 : w_ang;
        r_scale <= n_scale[34] ? 64'sd0 : 64'(n_scale);
        r_dy    <= $signed({15'd0, n_dabs, 20'd0});
        r_dz    <= (n_diff == 29'sd0);
    end

    logic signed [63:0] w_g, w_dy3, w_hx, w_h, w_g2;
    logic               w_dz3, w_dz2;

    gcd_mul #(.SHIFT(41)) u_mul_arc (.i_clk(i_clk), .i_a(r_scale), .i_b(r_ang), .o_p(w_g));
    gcd_delay #(.W(65), .DEPTH(3)) u_dly_dy (
        .i_clk(i_clk), .i_d({r_dz, r_dy}), .o_q({w_dz3, w_dy3})
    );

    gcd_cordic #(.STAGES(N), .VECTORING(1'b1)) u_vec_hyp (
        .i_clk(i_clk), .i_x(w_g), .i_y($signed(w_dy3)), .i_z(64'sd0),
        .o_x(w_hx), .o_y(), .o_z()
    );
    gcd_mul u_mul_hyp (.i_clk(i_clk), .i_a(w_hx), .i_b(K_Q61), .o_p(w_h));
    gcd_delay #(.W(65), .DEPTH(N + 3)) u_dly_g (
        .i_clk(i_clk), .i_d({w_dz3, w_g}), .o_q({w_dz2, w_g2})
    );

    // ---- round Q20 to mm and clamp
    logic signed [63:0] n_v;
    logic [63:0]        n_mm;
    logic [34:0]        r_dist;
    logic               r_sat;

    always_comb begin
        n_v  = w_dz2 ? $signed(w_g2) : w_h;
        if (n_v[63]) begin
            n_v = 64'sd0;
        end
        n_mm = (64'(n_v) + (64'd1 << 19)) >> 20;
    end

    always_ff @(posedge i_clk) begin
        if (n_mm > 64'(DIST_MAX)) begin
            r_dist <= DIST_MAX;
            r_sat  <= 1'b1;
        end else begin
            r_dist <= n_mm[34:0];
            r_sat  <= 1'b0;
        end
    end

    // ---- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= RADIUS_RESET;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    assign busy          = 1'b0;
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_vld[LAT-1];
    assign o_distance_mm = r_dist;
    assign o_saturated   = r_sat;

endmodule

>>> sv/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks on the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module gcd_checker
    import gcd_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] i_lon_a,
    input  logic signed [30:0] i_lat_a,
    input  logic signed [27:0] i_alt_a,
    input  logic signed [31:0] i_lon_b,
    input  logic signed [30:0] i_lat_b,
    input  logic signed [27:0] i_alt_b,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [32:0]        i_cfg_data,
    input  logic               o_valid,
    input  logic [34:0]        o_distance_mm,
    input  logic               o_saturated
);

    localparam int LAT = 25 + 4 * CORDIC_STAGES;

    // every result word traces back to a matching start
    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result word without matching start");

    // no word is dropped
    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && $past(i_rst_n, LAT)) |-> ##LAT o_valid)
        else $error("start without result word");

    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_distance_mm == DIST_MAX))
        else $error("saturated word not clamped");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("pipeline refused a word");

endmodule

bind great_circle_distance gcd_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_gcd_checker (.*);
